@@ rtl/timer_min_heap_defines.svh @@
// ----------------------------------------------------------------------------
// timer_min_heap_defines
// assertion macros used by the timer heap rtl
// ----------------------------------------------------------------------------
`ifndef TIMER_MIN_HEAP_DEFINES_SVH
`define TIMER_MIN_HEAP_DEFINES_SVH

// same-cycle implication
`define TMH_ASSERT_IMPL(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TMH_ASSERT_NEXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/tmh_pkg.sv @@
// ----------------------------------------------------------------------------
// tmh_pkg
// types and constants of the timer min-heap queue
// ----------------------------------------------------------------------------
package tmh_pkg;

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_ADJUST = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;
   localparam logic [1:0] FUNC_TICK   = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;
   localparam logic [1:0] STATUS_DUP    = 2'd3;

   localparam int MAX_RESULTS = 32;
   localparam int FIRE_CNT_W  = 6;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  timer_id;
      logic [31:0] expire_time;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [7:0] fired_id;
      logic       fired;
      logic [1:0] status;
      logic [5:0] occupancy;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS_RD,
      ST_LAST_RD,
      ST_UP,
      ST_UP_CMP,
      ST_DN,
      ST_DN_L,
      ST_DN_R,
      ST_DN_MV,
      ST_DONE,
      ST_TK_RD,
      ST_TK_CHK
   } state_type;

endpackage

@@ rtl/tmh_ram.sv @@
// ----------------------------------------------------------------------------
// tmh_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/tmh_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmh_ctrl
// heap sequencer: sift up/down one level at a time with one shared comparator
// ----------------------------------------------------------------------------
module tmh_ctrl import tmh_pkg::*; #(
   parameter int HEAP_DEPTH = 32,
   parameter int ID_COUNT   = 256,
   parameter int TIME_BITS  = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req,
   input  logic     out_free,
   output emit_type emit
);

   localparam int KEY_W  = (TIME_BITS < 32) ? TIME_BITS : 32;
   localparam int ID_TAB = (ID_COUNT < 256) ? ID_COUNT : 256;
   localparam int IDX_W  = $clog2(ID_TAB);
   localparam int POS_W  = $clog2(HEAP_DEPTH);
   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int CX_W   = POS_W + 2;
   localparam int ENT_W  = KEY_W + 8;

   state_type state_ff, state_in;
   logic [1:0]            func_ff, func_in;
   logic [7:0]            id_ff, id_in;
   logic [KEY_W-1:0]      exp_ff, exp_in;
   logic [KEY_W-1:0]      now_ff, now_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [7:0]            mid_ff, mid_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [KEY_W-1:0]      bk_ff, bk_in;
   logic [7:0]            bid_ff, bid_in;
   logic [POS_W-1:0]      bpos_ff, bpos_in;
   logic                  bsel_ff, bsel_in;
   logic [1:0]            status_ff, status_in;
   logic                  pend_ff, pend_in;
   logic [7:0]            pid_ff, pid_in;
   logic [FIRE_CNT_W-1:0] n_ff, n_in;
   logic [ID_TAB-1:0]     present_ff, present_in;

   logic             h_we, h_re, p_we;
   logic [POS_W-1:0] h_waddr, h_raddr, p_wdata, p_rdata;
   logic [ENT_W-1:0] h_wdata, h_rdata;
   logic [IDX_W-1:0] p_waddr;
   logic [KEY_W-1:0] r_key;
   logic [7:0]       r_id;

   logic [KEY_W-1:0] cmp_a, cmp_b;
   logic             lt;

   logic [CX_W-1:0]  lch, rch;
   logic [POS_W-1:0] pos_m1, parent;
   logic             id_ok;
   logic [IDX_W-1:0] req_idx;
   logic             more;

   tmh_ram #(.WIDTH(ENT_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .re    (h_re),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   tmh_ram #(.WIDTH(POS_W), .DEPTH(ID_TAB)) u_pos_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .re    (req_valid && req_ready),
      .raddr (req_idx),
      .rdata (p_rdata)
   );

   assign r_key   = h_rdata[ENT_W-1:8];
   assign r_id    = h_rdata[7:0];
   assign lch     = {1'b0, pos_ff, 1'b1};
   assign rch     = {1'b0, pos_ff, 1'b0} + CX_W'(2);
   assign pos_m1  = pos_ff - 1'b1;
   assign parent  = pos_m1 >> 1;
   assign id_ok   = 32'(req.timer_id) < ID_COUNT;
   assign req_idx = req.timer_id[IDX_W-1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign lt = cmp_a < cmp_b;
   assign more = (cnt_ff != '0) && lt && (n_ff < FIRE_CNT_W'(MAX_RESULTS));

   // shared comparator operand select
   always_comb begin
      cmp_a = r_key;
      cmp_b = key_ff;
      case (state_ff)
         ST_UP_CMP: begin
            cmp_a = key_ff;
            cmp_b = r_key;
         end
         ST_DN_R: begin
            cmp_a = r_key;
            cmp_b = bk_ff;
         end
         ST_TK_CHK: begin
            cmp_a = r_key;
            cmp_b = now_ff;
         end
         default: begin
            cmp_a = r_key;
            cmp_b = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         present_ff <= '0;
         pend_ff    <= 1'b0;
         n_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         present_ff <= present_in;
         pend_ff    <= pend_in;
         n_ff       <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      id_ff     <= id_in;
      exp_ff    <= exp_in;
      now_ff    <= now_in;
      key_ff    <= key_in;
      mid_ff    <= mid_in;
      pos_ff    <= pos_in;
      bk_ff     <= bk_in;
      bid_ff    <= bid_in;
      bpos_ff   <= bpos_in;
      bsel_ff   <= bsel_in;
      status_ff <= status_in;
      pid_ff    <= pid_in;
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      id_in      = id_ff;
      exp_in     = exp_ff;
      now_in     = now_ff;
      key_in     = key_ff;
      mid_in     = mid_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;
      bk_in      = bk_ff;
      bid_in     = bid_ff;
      bpos_in    = bpos_ff;
      bsel_in    = bsel_ff;
      status_in  = status_ff;
      pend_in    = pend_ff;
      pid_in     = pid_ff;
      n_in       = n_ff;
      present_in = present_ff;
      h_we       = 1'b0;
      h_waddr    = pos_ff;
      h_wdata    = {key_ff, mid_ff};
      h_re       = 1'b0;
      h_raddr    = '0;
      p_we       = 1'b0;
      p_waddr    = mid_ff[IDX_W-1:0];
      p_wdata    = pos_ff;
      emit       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req.func;
               id_in     = req.timer_id;
               exp_in    = req.expire_time[KEY_W-1:0];
               now_in    = req.now_time[KEY_W-1:0];
               status_in = STATUS_OK;
               case (req.func)
                  FUNC_ADD: begin
                     if (!id_ok) begin
                        status_in = STATUS_ABSENT;
                        state_in  = ST_DONE;
                     end else if (present_ff[req_idx]) begin
                        status_in = STATUS_DUP;
                        state_in  = ST_DONE;
                     end else if (cnt_ff == CNT_W'(HEAP_DEPTH)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        key_in  = req.expire_time[KEY_W-1:0];
                        mid_in  = req.timer_id;
                        pos_in  = cnt_ff[POS_W-1:0];
                        cnt_in  = cnt_ff + 1'b1;
                        present_in[req_idx] = 1'b1;
                        state_in = ST_UP;
                     end
                  end
                  FUNC_TICK: begin
                     n_in     = '0;
                     pend_in  = 1'b0;
                     state_in = ST_TK_RD;
                  end
                  default: begin
                     if (!(id_ok && present_ff[req_idx])) begin
                        status_in = STATUS_ABSENT;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_POS_RD;
                     end
                  end
               endcase
            end
         end
         ST_POS_RD: begin
            pos_in = p_rdata;
            if (func_ff == FUNC_ADJUST) begin
               key_in   = exp_ff;
               mid_in   = id_ff;
               state_in = ST_UP;
            end else begin
               present_in[id_ff[IDX_W-1:0]] = 1'b0;
               cnt_in = cnt_ff - 1'b1;
               if (CNT_W'(p_rdata) == cnt_ff - 1'b1) begin
                  state_in = ST_DONE;
               end else begin
                  h_re     = 1'b1;
                  h_raddr  = POS_W'(cnt_ff - 1'b1);
                  state_in = ST_LAST_RD;
               end
            end
         end
         ST_LAST_RD: begin
            key_in   = r_key;
            mid_in   = r_id;
            state_in = ST_UP;
         end
         ST_UP: begin
            if (pos_ff == '0) begin
               state_in = ST_DN;
            end else begin
               h_re     = 1'b1;
               h_raddr  = parent;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (!lt) begin
               state_in = ST_DN;
            end else begin
               h_we     = 1'b1;
               h_wdata  = h_rdata;
               p_we     = 1'b1;
               p_waddr  = r_id[IDX_W-1:0];
               pos_in   = parent;
               state_in = ST_UP;
            end
         end
         ST_DN: begin
            if (lch >= CX_W'(cnt_ff)) begin
               h_we     = 1'b1;
               p_we     = 1'b1;
               state_in = (func_ff == FUNC_TICK) ? ST_TK_RD : ST_DONE;
            end else begin
               h_re     = 1'b1;
               h_raddr  = lch[POS_W-1:0];
               state_in = ST_DN_L;
            end
         end
         ST_DN_L: begin
            bsel_in = lt;
            bk_in   = lt ? r_key : key_ff;
            bid_in  = r_id;
            bpos_in = lch[POS_W-1:0];
            if (rch < CX_W'(cnt_ff)) begin
               h_re     = 1'b1;
               h_raddr  = rch[POS_W-1:0];
               state_in = ST_DN_R;
            end else begin
               state_in = ST_DN_MV;
            end
         end
         ST_DN_R: begin
            if (lt) begin
               bsel_in = 1'b1;
               bk_in   = r_key;
               bid_in  = r_id;
               bpos_in = rch[POS_W-1:0];
            end
            state_in = ST_DN_MV;
         end
         ST_DN_MV: begin
            if (bsel_ff) begin
               h_we     = 1'b1;
               h_wdata  = {bk_ff, bid_ff};
               p_we     = 1'b1;
               p_waddr  = bid_ff[IDX_W-1:0];
               pos_in   = bpos_ff;
               state_in = ST_DN;
            end else begin
               h_we     = 1'b1;
               p_we     = 1'b1;
               state_in = (func_ff == FUNC_TICK) ? ST_TK_RD : ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit.valid         = 1'b1;
               emit.rsp.status    = status_ff;
               emit.rsp.occupancy = 6'(cnt_ff);
               emit.rsp.last      = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_TK_RD: begin
            h_re     = 1'b1;
            h_raddr  = '0;
            state_in = ST_TK_CHK;
         end
         ST_TK_CHK: begin
            if (out_free || (!pend_ff && more)) begin
               if (pend_ff || !more) begin
                  emit.valid         = 1'b1;
                  emit.rsp.fired_id  = pend_ff ? pid_ff : 8'd0;
                  emit.rsp.fired     = pend_ff;
                  emit.rsp.status    = STATUS_OK;
                  emit.rsp.occupancy = 6'(cnt_ff);
                  emit.rsp.last      = !more;
               end
               if (more) begin
                  pend_in = 1'b1;
                  pid_in  = r_id;
                  present_in[r_id[IDX_W-1:0]] = 1'b0;
                  n_in    = n_ff + 1'b1;
                  cnt_in  = cnt_ff - 1'b1;
                  pos_in  = '0;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_TK_RD;
                  end else begin
                     h_re     = 1'b1;
                     h_raddr  = POS_W'(cnt_ff - 1'b1);
                     state_in = ST_LAST_RD;
                  end
               end else begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/timer_min_heap.sv @@
// ----------------------------------------------------------------------------
// timer_min_heap
// timer queue kept as an indexed binary min-heap ordered by expiry time
// ----------------------------------------------------------------------------
// req_ carries one transaction: add, adjust, delete or tick. add, adjust and
// delete each answer with one rsp_ transaction (last set). a tick answers with
// one transaction per expired timer, earliest first, at most 32, the final one
// with last set; with nothing expired it answers one empty transaction.
// each heap level climbed or descended costs a read of the heap ram's single
// read port and a pass through the one shared key comparator, and a tick
// restores the heap after removing each fired timer. req_ready is low while
// an item is being worked on.
// reset clears the timer count and the presence flags; the heap and position
// rams need no clearing, so the block is ready the cycle after reset.
// a stalled rsp_ready holds the result in the output register and the
// sequencer waits before producing the next one.
// ----------------------------------------------------------------------------
module timer_min_heap import tmh_pkg::*; #(
   parameter int HEAP_DEPTH = 32,
   parameter int ID_COUNT   = 256,
   parameter int TIME_BITS  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

`include "timer_min_heap_defines.svh"

   emit_type emit;
   logic     out_free;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   tmh_ctrl #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .ID_COUNT   (ID_COUNT),
      .TIME_BITS  (TIME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .out_free  (out_free),
      .emit      (emit)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = emit.valid ? emit.rsp : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `TMH_ASSERT_NEXT(a_busy_after_req, reset, req_valid && req_ready, !req_ready)
   `TMH_ASSERT_IMPL(a_fired_ok, reset, rsp_valid && rsp.fired, rsp.status == STATUS_OK)
   `TMH_ASSERT_IMPL(a_plain_last, reset, rsp_valid && !rsp.fired, rsp.last)

endmodule
